// ===== rtl/pedf_pkg.sv =====
`default_nettype none
package pedf_pkg;

    // fixed field widths
    localparam int CLS_W      = 3;
    localparam int VID_W      = 12;
    localparam int DL_W       = 32;
    localparam int BITS_W     = 14;
    localparam int TAG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 5;
    localparam int GAP_W      = 10;
    localparam int VCNT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int ENT_W      = DL_W + BITS_W + TAG_W;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 80;

    // parameter defaults
    localparam int DEF_CLASSES     = 8;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_VLAN_SLOTS  = 4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd3;

    // input commands
    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // transmitter phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TX   = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VLAN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VLAN_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd5;

    localparam logic [GAP_W-1:0] GAP_RESET = 10'd96;

    typedef struct packed {
        logic              latch_in;
        logic              rd_pred;
        logic              rd_head;
        logic              wr_moved;
        logic              wr_new;
        logic              pos_load;
        logic              pos_dec;
        logic              cnt_inc;
        logic              sel_latch;
        logic              pop;
        logic              tick_step;
        logic              phase_idle;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } pedf_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic vlan_pass;
        logic full;
        logic cnt_zero;
        logic pos_one;
        logic dl_greater;
        logic any_ready;
        logic gap_end;
        logic phase_idle;
        logic out_free;
    } pedf_sts_t;

endpackage
`default_nettype wire

// ===== rtl/priority_edf_tx_scheduler.sv =====
`default_nettype none
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  enqueue or bit-time tick
// m_        out        m_tvalid / m_tready  enqueue, filter, drop, start results
// cfg_      in         cfg_wr_en            register writes, no read-back
//
// one item at a time: a tick steps the tx timer, or, when it ends the gap, selects and
// pops the next frame; filter or drop only emit their result; an enqueue walks the
// sorted queue moving entries up, writes the new entry and may start transmission
// synchronous active-low reset clears counts, peaks, phase and config; the
// queue ram is never cleared since only filled entries are read
// a stalled result holds the controller until the output register frees up
module priority_edf_tx_scheduler
    import pedf_pkg::*;
#(
    parameter int CLASSES     = DEF_CLASSES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int VLAN_SLOTS  = DEF_VLAN_SLOTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // prio_class, vlan_id, deadline, frame_bits, frame_tag, zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_class, class_length, class_peak, out_tag, out_bits, out_deadline, zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // kind
    output logic [KIND_W-1:0]          m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    pedf_cmd_t cmd;
    pedf_sts_t sts;

    // sequencer for filtering, sorted insert and pop
    pedf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queue ram, counters, tx timer and output register
    pedf_dp #(
        .CLASSES     (CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VLAN_SLOTS  (VLAN_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // sequencer leaves idle right after taking an item
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // a start result always closes its item
    a_start_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_START |-> m_tlast)
        else $error("start result without last");

    // no result is issued while the output register is still held
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result issued into a full output register");

    // a pop only happens together with its start result
    a_pop_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> cmd.emit && cmd.emit_kind == KIND_START)
        else $error("pop without start result");

endmodule
`default_nettype wire

// ===== rtl/pedf_ctrl.sv =====
`default_nettype none
module pedf_ctrl
    import pedf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire pedf_sts_t sts,
    output pedf_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_WRNEW  = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_EMIT0  = 4'd6;
    localparam logic [3:0] S_SEL    = 4'd7;
    localparam logic [3:0] S_RDH    = 4'd8;
    localparam logic [3:0] S_POP    = 4'd9;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.is_tick) begin
                    if (sts.gap_end) begin
                        state_next = S_SEL;
                    end else begin
                        cmd.tick_step = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else if (!sts.vlan_pass || sts.full) begin
                    if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = sts.vlan_pass ? KIND_DROP : KIND_FILTER;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.pos_load = 1'b1;
                    state_next   = sts.cnt_zero ? S_WRNEW : S_RD;
                end
            end
            S_RD: begin
                cmd.rd_pred = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP: begin
                if (sts.dl_greater) begin
                    cmd.wr_moved = 1'b1;
                    cmd.pos_dec  = 1'b1;
                    state_next   = sts.pos_one ? S_WRNEW : S_RD;
                end else begin
                    cmd.wr_new = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_WRNEW: begin
                cmd.wr_new = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.cnt_inc = 1'b1;
                state_next  = S_EMIT0;
            end
            S_EMIT0: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ENQ;
                    cmd.emit_last = !sts.phase_idle;
                    state_next    = sts.phase_idle ? S_SEL : S_IDLE;
                end
            end
            S_SEL: begin
                if (sts.any_ready) begin
                    cmd.sel_latch = 1'b1;
                    state_next    = S_RDH;
                end else begin
                    cmd.phase_idle = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RDH: begin
                cmd.rd_head = 1'b1;
                state_next  = S_POP;
            end
            S_POP: begin
                if (sts.out_free) begin
                    cmd.pop       = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_START;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pedf_dp.sv =====
`default_nettype none
module pedf_dp
    import pedf_pkg::*;
#(
    parameter int CLASSES     = DEF_CLASSES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int VLAN_SLOTS  = DEF_VLAN_SLOTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]            s_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire pedf_cmd_t             cmd,
    output pedf_sts_t                  sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [KIND_W-1:0]          m_tuser,
    output logic                       m_tlast
);

    localparam int CIW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = $clog2(CLASSES * QUEUE_DEPTH);

    // config
    logic [VCNT_W-1:0] vcnt_reg;
    logic [VID_W-1:0]  vlan_reg [VLAN_SLOTS];
    logic [GAP_W-1:0]  gap_reg;

    // latched item
    logic              cmd_reg;
    logic [CIW-1:0]    cls_reg;
    logic [VID_W-1:0]  vid_reg;
    logic [DL_W-1:0]   dl_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [TAG_W-1:0]  tag_reg;

    // queue state
    logic [CW-1:0]     count_reg [CLASSES];
    logic [CW-1:0]     peak_reg  [CLASSES];
    logic [PW-1:0]     head_reg  [CLASSES];
    logic [CW-1:0]     pos_reg;
    logic [CIW-1:0]    sel_reg;
    logic [1:0]        phase_reg;
    logic [BITS_W-1:0] left_reg;
    logic [ENT_W-1:0]  queue_mem [CLASSES * QUEUE_DEPTH];
    logic [ENT_W-1:0]  rd_q;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [KIND_W-1:0]     m_tuser_reg;
    logic                  m_tlast_reg;

    logic [CLS_W-1:0]  in_prio;
    logic [CIW-1:0]    in_cls;
    logic [CW-1:0]     n_cls;
    logic [CIW-1:0]    sel_next;
    logic              any_ready;
    logic              vlan_hit;
    logic [VCNT_W-1:0] vlan_n;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [DL_W-1:0]   rd_dl;
    logic [BITS_W-1:0] rd_bits;
    logic [TAG_W-1:0]  rd_tag;
    logic              out_free;

    function automatic logic [PW-1:0] slot_wrap(input logic [PW-1:0] base,
                                                input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (PW+1)'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [CIW-1:0] c,
                                               input logic [PW-1:0] slot);
        return AW'(AW'(c) * AW'(QUEUE_DEPTH)) + AW'(slot);
    endfunction

    assign in_prio = s_tdata[2:0];
    assign in_cls  = ({1'b0, in_prio} >= (CLS_W+1)'(CLASSES)) ? CIW'(CLASSES - 1)
                                                              : in_prio[CIW-1:0];
    assign n_cls   = count_reg[cls_reg];
    assign {rd_dl, rd_bits, rd_tag} = rd_q;
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_addr = cmd.rd_head
        ? mem_addr(sel_reg, head_reg[sel_reg])
        : mem_addr(cls_reg, slot_wrap(head_reg[cls_reg], PW'(pos_reg - 1'b1)));
    assign wr_addr = mem_addr(cls_reg, slot_wrap(head_reg[cls_reg], PW'(pos_reg)));

    always_comb begin
        vlan_n   = (vcnt_reg > VCNT_W'(VLAN_SLOTS)) ? VCNT_W'(VLAN_SLOTS) : vcnt_reg;
        vlan_hit = 1'b0;
        for (int i = 0; i < VLAN_SLOTS; i++) begin
            if (VCNT_W'(i) < vlan_n && vlan_reg[i] == vid_reg) begin
                vlan_hit = 1'b1;
            end
        end
    end

    // highest non-empty class wins
    always_comb begin
        sel_next  = '0;
        any_ready = 1'b0;
        for (int c = 0; c < CLASSES; c++) begin
            if (count_reg[c] != '0) begin
                sel_next  = CIW'(c);
                any_ready = 1'b1;
            end
        end
    end

    always_comb begin
        sts.is_tick    = (cmd_reg == CMD_TICK);
        sts.vlan_pass  = (vlan_n == '0) || vlan_hit;
        sts.full       = (n_cls >= CW'(QUEUE_DEPTH));
        sts.cnt_zero   = (n_cls == '0);
        sts.pos_one    = (pos_reg == CW'(1));
        sts.dl_greater = (rd_dl > dl_reg);
        sts.any_ready  = any_ready;
        sts.gap_end    = (phase_reg == PH_GAP) && (left_reg <= BITS_W'(1));
        sts.phase_idle = (phase_reg == PH_IDLE);
        sts.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg <= '0;
            gap_reg  <= GAP_RESET;
            for (int i = 0; i < VLAN_SLOTS; i++) begin
                vlan_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_VLAN_COUNT) begin
                vcnt_reg <= cfg_wdata[VCNT_W-1:0];
            end
            if (cfg_addr == REG_GAP) begin
                gap_reg <= cfg_wdata[GAP_W-1:0];
            end
            for (int i = 0; i < VLAN_SLOTS; i++) begin
                if (cfg_addr == REG_VLAN_0 + CFG_IDX_W'(i)) begin
                    vlan_reg[i] <= cfg_wdata[VID_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg  <= s_tuser[0];
            cls_reg  <= in_cls;
            vid_reg  <= s_tdata[14:3];
            dl_reg   <= s_tdata[46:15];
            bits_reg <= s_tdata[60:47];
            tag_reg  <= s_tdata[76:61];
        end
        if (cmd.pos_load) begin
            pos_reg <= n_cls;
        end else if (cmd.pos_dec) begin
            pos_reg <= pos_reg - 1'b1;
        end
        if (cmd.sel_latch) begin
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_moved) begin
            queue_mem[wr_addr] <= rd_q;
        end else if (cmd.wr_new) begin
            queue_mem[wr_addr] <= {dl_reg, bits_reg, tag_reg};
        end
        if (cmd.rd_pred || cmd.rd_head) begin
            rd_q <= queue_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            for (int c = 0; c < CLASSES; c++) begin
                count_reg[c] <= '0;
                peak_reg[c]  <= '0;
                head_reg[c]  <= '0;
            end
        end else begin
            if (cmd.cnt_inc) begin
                count_reg[cls_reg] <= n_cls + 1'b1;
                if (n_cls + 1'b1 > peak_reg[cls_reg]) begin
                    peak_reg[cls_reg] <= n_cls + 1'b1;
                end
            end
            if (cmd.pop) begin
                count_reg[sel_reg] <= count_reg[sel_reg] - 1'b1;
                head_reg[sel_reg]  <= slot_wrap(head_reg[sel_reg], PW'(1));
                phase_reg          <= PH_TX;
                left_reg           <= (rd_bits == '0) ? BITS_W'(1) : rd_bits;
            end else if (cmd.phase_idle) begin
                phase_reg <= PH_IDLE;
                left_reg  <= '0;
            end else if (cmd.tick_step) begin
                if (phase_reg == PH_TX && left_reg <= BITS_W'(1)) begin
                    phase_reg <= PH_GAP;
                    left_reg  <= (gap_reg == '0) ? BITS_W'(1) : BITS_W'(gap_reg);
                end else if (phase_reg != PH_IDLE) begin
                    left_reg <= left_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tuser_reg <= cmd.emit_kind;
            m_tlast_reg <= cmd.emit_last;
            if (cmd.emit_kind == KIND_START) begin
                m_tdata_reg <= {5'd0, rd_dl, rd_bits, rd_tag,
                                LEN_W'(peak_reg[sel_reg]),
                                LEN_W'(count_reg[sel_reg] - 1'b1),
                                CLS_W'(sel_reg)};
            end else begin
                m_tdata_reg <= {5'd0, dl_reg, bits_reg, tag_reg,
                                LEN_W'(peak_reg[cls_reg]),
                                LEN_W'(n_cls),
                                CLS_W'(cls_reg)};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pedf_pkg::*;

    localparam int NCLS        = DEF_CLASSES;
    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int NSLOTS      = DEF_VLAN_SLOTS;
    localparam int RAND_ITEMS  = 1950;
    localparam int SETTLE_CYC  = 80;       // longest enqueue walk plus start, with margin
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic              cmd;
        logic [CLS_W-1:0]  cls;
        logic [VID_W-1:0]  vid;
        logic [DL_W-1:0]   dl;
        logic [BITS_W-1:0] fbits;
        logic [TAG_W-1:0]  tag;
    } frame_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  peak;
        logic [TAG_W-1:0]  tag;
        logic [BITS_W-1:0] fbits;
        logic [DL_W-1:0]   dl;
        logic              last;
    } sched_result_t;

    typedef struct {
        logic [DL_W-1:0]   dl;
        logic [BITS_W-1:0] fbits;
        logic [TAG_W-1:0]  tag;
    } queued_frame_t;

    // scheduler model plus the queue of results it still owes
    class edf_scoreboard;
        queued_frame_t   cls_q[NCLS][QDEPTH];
        int              cls_len[NCLS];
        int              cls_peak[NCLS];
        logic [1:0]      phase;
        int              ticks_left;
        int              vlan_cnt;
        logic [VID_W-1:0] vlan_ok[NSLOTS];
        int              gap;
        sched_result_t   owed[$];
        int              errors;
        int              n_checked;
        int              n_kind[4];

        function new();
            for (int c = 0; c < NCLS; c++) begin
                cls_len[c]  = 0;
                cls_peak[c] = 0;
            end
            phase      = PH_IDLE;
            ticks_left = 0;
            vlan_cnt   = 0;
            for (int i = 0; i < NSLOTS; i++) vlan_ok[i] = '0;
            gap        = GAP_RESET;
            errors     = 0;
            n_checked  = 0;
            for (int k = 0; k < 4; k++) n_kind[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_VLAN_COUNT) vlan_cnt = val[VCNT_W-1:0];
            else if (idx >= REG_VLAN_0 && idx < REG_VLAN_0 + NSLOTS)
                vlan_ok[idx - REG_VLAN_0] = val[VID_W-1:0];
            else if (idx == REG_GAP) gap = val[GAP_W-1:0];
        endfunction

        function void owe(logic [KIND_W-1:0] kind, int c, logic [TAG_W-1:0] tag,
                          logic [BITS_W-1:0] fb, logic [DL_W-1:0] dl, logic last);
            sched_result_t r;
            r.kind  = kind;
            r.cls   = CLS_W'(c);
            r.len   = LEN_W'(cls_len[c]);
            r.peak  = LEN_W'(cls_peak[c]);
            r.tag   = tag;
            r.fbits = fb;
            r.dl    = dl;
            r.last  = last;
            owed = {owed, r};
        endfunction

        // pop the earliest frame of the highest non-empty class
        function void launch_next();
            queued_frame_t e;
            for (int c = NCLS - 1; c >= 0; c--) begin
                if (cls_len[c] > 0) begin
                    e = cls_q[c][0];
                    for (int i = 0; i < cls_len[c] - 1; i++) cls_q[c][i] = cls_q[c][i+1];
                    cls_len[c]--;
                    phase      = PH_TX;
                    ticks_left = (e.fbits == 0) ? 1 : e.fbits;
                    owe(KIND_START, c, e.tag, e.fbits, e.dl, 1'b1);
                    return;
                end
            end
            phase      = PH_IDLE;
            ticks_left = 0;
        endfunction

        function bit vlan_allowed(logic [VID_W-1:0] vid);
            int n;
            n = (vlan_cnt > NSLOTS) ? NSLOTS : vlan_cnt;
            if (n == 0) return 1;
            for (int i = 0; i < n; i++) if (vlan_ok[i] == vid) return 1;
            return 0;
        endfunction

        // accepted input transfer
        function void note(frame_item_t it);
            int c, pos;
            bit was_idle;
            if (it.cmd == CMD_TICK) begin
                if (phase == PH_TX) begin
                    if (ticks_left <= 1) begin
                        phase      = PH_GAP;
                        ticks_left = (gap == 0) ? 1 : gap;
                    end else ticks_left--;
                end else if (phase == PH_GAP) begin
                    if (ticks_left <= 1) launch_next();
                    else ticks_left--;
                end
                return;
            end
            c = (it.cls >= NCLS) ? NCLS - 1 : it.cls;
            if (!vlan_allowed(it.vid)) begin
                owe(KIND_FILTER, c, it.tag, it.fbits, it.dl, 1'b1);
                return;
            end
            if (cls_len[c] >= QDEPTH) begin
                owe(KIND_DROP, c, it.tag, it.fbits, it.dl, 1'b1);
                return;
            end
            // sorted insert, equal deadlines stay behind earlier arrivals
            pos = cls_len[c];
            while (pos > 0 && cls_q[c][pos-1].dl > it.dl) begin
                cls_q[c][pos] = cls_q[c][pos-1];
                pos--;
            end
            cls_q[c][pos].dl    = it.dl;
            cls_q[c][pos].fbits = it.fbits;
            cls_q[c][pos].tag   = it.tag;
            cls_len[c]++;
            if (cls_len[c] > cls_peak[c]) cls_peak[c] = cls_len[c];
            was_idle = (phase == PH_IDLE);
            owe(KIND_ENQ, c, it.tag, it.fbits, it.dl, !was_idle);
            if (was_idle) launch_next();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
            errors++;
        endtask

        // accepted result transfer
        task check(sched_result_t r);
            sched_result_t w;
            if (owed.size() == 0) begin
                report_mismatch("unexpected result, kind", r.kind, 0);
                return;
            end
            w = owed.pop_front();
            n_checked++;
            n_kind[w.kind]++;
            if (r.kind  !== w.kind)  report_mismatch("kind", r.kind, w.kind);
            if (r.cls   !== w.cls)   report_mismatch("class", r.cls, w.cls);
            if (r.len   !== w.len)   report_mismatch("class_length", r.len, w.len);
            if (r.peak  !== w.peak)  report_mismatch("class_peak", r.peak, w.peak);
            if (r.tag   !== w.tag)   report_mismatch("tag", r.tag, w.tag);
            if (r.fbits !== w.fbits) report_mismatch("frame_bits", r.fbits, w.fbits);
            if (r.dl    !== w.dl)    report_mismatch("deadline", r.dl, w.dl);
            if (r.last  !== w.last)  report_mismatch("last", r.last, w.last);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    edf_scoreboard sched_sb;
    bit            no_idle = 1'b0;   // long stretch with both sides always ready
    int            items_sent = 0;
    int            cycles = 0;
    logic [VID_W-1:0] cur_vlans[NSLOTS];

    priority_edf_tx_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side backpressure, about 13 stalls in a hundred
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 13);
    end

    // transfer monitor: values seen here are the ones before the edge
    always @(posedge aclk) begin
        frame_item_t   it;
        sched_result_t r;
        if (aresetn && sched_sb != null) begin
            if (s_tvalid && s_tready) begin
                it.cmd   = s_tuser[0];
                it.cls   = s_tdata[2:0];
                it.vid   = s_tdata[14:3];
                it.dl    = s_tdata[46:15];
                it.fbits = s_tdata[60:47];
                it.tag   = s_tdata[76:61];
                sched_sb.note(it);
            end
            if (m_tvalid && m_tready) begin
                r.kind  = m_tuser;
                r.cls   = m_tdata[2:0];
                r.len   = m_tdata[7:3];
                r.peak  = m_tdata[12:8];
                r.tag   = m_tdata[28:13];
                r.fbits = m_tdata[42:29];
                r.dl    = m_tdata[74:43];
                r.last  = m_tlast;
                sched_sb.check(r);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** priority_edf_tx_scheduler: FAILED **");
            $finish;
        end
    end

    // one input transfer; valid stays high across back-to-back items
    task push_item(frame_item_t it);
        if (!no_idle && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {3'b000, it.tag, it.fbits, it.dl, it.vid, it.cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task send_frame(int c, int vid, logic [DL_W-1:0] dl, int fb, int tag);
        frame_item_t it;
        it.cmd   = CMD_ENQ;
        it.cls   = CLS_W'(c);
        it.vid   = VID_W'(vid);
        it.dl    = dl;
        it.fbits = BITS_W'(fb);
        it.tag   = TAG_W'(tag);
        push_item(it);
    endtask

    task send_ticks(int n);
        frame_item_t it;
        it.cmd   = CMD_TICK;
        it.cls   = CLS_W'($urandom);
        it.vid   = VID_W'($urandom);
        it.dl    = $urandom;
        it.fbits = BITS_W'($urandom);
        it.tag   = TAG_W'($urandom);
        for (int i = 0; i < n; i++) push_item(it);
    endtask

    // drain outstanding results and let the block go quiet
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sched_sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        sched_sb.set_reg(idx, CFG_DATA_W'(val));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task load_setting(int vcnt, int gap_val);
        for (int i = 0; i < NSLOTS; i++) begin
            cur_vlans[i] = VID_W'($urandom);
            write_reg(REG_VLAN_0 + CFG_IDX_W'(i), cur_vlans[i]);
        end
        write_reg(REG_VLAN_COUNT, vcnt);
        write_reg(REG_GAP, gap_val);
    endtask

    function logic [VID_W-1:0] pick_vid();
        if ($urandom_range(99) < 80) return cur_vlans[$urandom_range(NSLOTS-1)];
        return VID_W'($urandom);
    endfunction

    // random content with deadlines from a narrow pool so ties are common
    function logic [DL_W-1:0] pick_deadline();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task random_phase(int n_items);
        int target, c;
        target = items_sent + n_items;
        while (items_sent < target) begin
            no_idle = (items_sent > 700 && items_sent < 1000);
            if ($urandom_range(99) < 12) begin
                // fill one class past its depth to force drops
                c = $urandom_range(NCLS-1);
                for (int i = 0; i < QDEPTH + 3; i++)
                    send_frame(c, pick_vid(), pick_deadline(), $urandom_range(4),
                               $urandom);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_frame($urandom_range(NCLS-1), pick_vid(), pick_deadline(),
                               $urandom_range(12), $urandom);
            end
            send_ticks($urandom_range(60, 1));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sched_sb = new();
        for (int i = 0; i < NSLOTS; i++) cur_vlans[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, no filter, gap 96
        send_frame(0, 0, 32'd0, 0, 16'h0000);                 // zero-length frame starts at once
        send_frame(7, 12'hFFF, 32'hFFFF_FFFF, 200, 16'hFFFF);   // long frame, latest deadline
        send_frame(7, 12'h555, 32'd100, 5, 16'h1234);
        send_frame(7, 12'hAAA, 32'd100, 6, 16'h1235);         // equal deadline, stays behind
        send_frame(7, 12'h001, 32'd50, 7, 16'h1236);          // earlier deadline goes first
        for (int c = 0; c < NCLS; c++) send_frame(c, c, 32'd10 * c, 3, c);
        send_ticks(8);
        settle();
        // a few frames go out with the reset gap, the rest drain later
        send_ticks(300);
        settle();

        // filtered: slots above the limit are saturated
        load_setting(7, 1);
        send_frame(3, cur_vlans[3], 32'd5, 2, 16'h0F0F);
        send_frame(3, cur_vlans[0] ^ 12'h800, 32'd5, 2, 16'hF0F0);
        send_ticks(10);
        settle();

        load_setting(0, 96);
        random_phase(300);
        settle();
        load_setting(2, 1);
        random_phase(300);
        settle();
        load_setting(7, 0);       // zero gap behaves as one tick
        random_phase(300);
        settle();
        load_setting(4, 1023);
        random_phase(300);
        settle();
        load_setting(1, 3);
        random_phase(300);
        // longest frame, highest class
        send_frame(7, cur_vlans[0], 32'hFFFF_FFFF, 16383, 16'hFFFF);
        send_ticks(4);
        settle();

        if (sched_sb.owed.size() != 0)
            sched_sb.report_mismatch("results never seen, count", sched_sb.owed.size(), 0);
        $display("covered %0d input items and %0d results", items_sent, sched_sb.n_checked);
        $display("enqueued %0d, filtered %0d, dropped %0d, started %0d", sched_sb.n_kind[0],
                 sched_sb.n_kind[1], sched_sb.n_kind[2], sched_sb.n_kind[3]);
        if (sched_sb.errors == 0) begin
            $display("** priority_edf_tx_scheduler: PASSED **");
        end else begin
            $display("** priority_edf_tx_scheduler: FAILED **");
        end
        $finish;
    end

endmodule

// ===== priority_edf_tx_scheduler.f =====
rtl/pedf_pkg.sv
rtl/pedf_ctrl.sv
rtl/pedf_dp.sv
rtl/priority_edf_tx_scheduler.sv
tb/tb.sv
